// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the receiver RTL.
// Plain text macros only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, switched off while rstn is low.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mcfr_pkg.sv =====
// Shared types and constants of the motor command frame receiver.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps

package mcfr_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] CFG_HEADER  = 3'd0;
    localparam logic [2:0] CFG_TRAILER = 3'd1;
    localparam logic [2:0] CFG_ENABLE  = 3'd2;
    localparam logic [2:0] CFG_DISABLE = 3'd3;

    // Register reset values
    localparam logic [7:0] HEADER_RST  = 8'h53;
    localparam logic [7:0] TRAILER_RST = 8'h45;
    localparam logic [7:0] ENABLE_RST  = 8'h01;
    localparam logic [7:0] DISABLE_RST = 8'h00;

    // First byte of a command burst ('A')
    localparam logic [7:0] CMD_MARK = 8'h41;

    // Number of motor slots on the result port
    localparam int MAX_MOTORS = 4;

    typedef enum logic [1:0] {
        REQ_NONE  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2
    } motor_req_t;

    // Control from the top level to the frame store
    typedef struct packed {
        logic write;   // a word is consumed this cycle
        logic last;    // it ends the burst
        logic clear;   // the frame passed its check: wipe the store
    } store_ctrl_t;

    // Frame check result
    typedef struct packed {
        logic                             frame_valid;
        logic [MAX_MOTORS-1:0][15:0]      preload;
        logic [MAX_MOTORS-1:0][15:0]      direction;
    } check_res_t;

    // Command decode result
    typedef struct packed {
        logic       command_seen;
        logic       report_enable;
        motor_req_t request;
    } cmd_res_t;

endpackage

// ===== rtl/motor_command_frame_receiver.sv =====
// Top level of the motor command frame receiver.
// Depends on mcfr_pkg, mcfr_frame_store, mcfr_frame_check, mcfr_cmd_decode
// and assert_macros.svh.
//
// Usage:
// - Input channel (s_valid/s_ready): one received byte per word, with
//   s_burst_end high on the last byte of a burst.
// - Result channel (m_valid/m_ready): one word per burst end, carrying the
//   frame check verdict, four motor preload/direction pairs (zero unless
//   the frame is valid), report enable, motor request and command flag.
// - Configuration: cfg_wr_en writes cfg_wr_data into register cfg_index
//   (0 header, 1 trailer, 2 enable code, 3 disable code); others ignored.
// - Throughput: one word per cycle while no burst-ending word waits for the
//   result register; store update, checksum tree and command decode complete in the input register.
// - Result: a burst-ending word passes from the input register into the
//   result register once that is free, and m_valid then rises.
// - Stall: while a result waits, bytes that do not end a burst keep flowing;
//   a burst-ending byte waits in the input register, and s_ready drops
//   only when that register is full and cannot drain.
// - Reset (aresetn low, synchronous): store cleared, write position zero,
//   report enable off, registers back to defaults, both channels empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module motor_command_frame_receiver #(
    parameter int FRAME_BYTES = 32,
    parameter int MOTOR_COUNT = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_burst_end,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_valid,
    output logic [15:0] m_preload_0,
    output logic [15:0] m_direction_0,
    output logic [15:0] m_preload_1,
    output logic [15:0] m_direction_1,
    output logic [15:0] m_preload_2,
    output logic [15:0] m_direction_2,
    output logic [15:0] m_preload_3,
    output logic [15:0] m_direction_3,
    output logic        m_report_enable,
    output logic [1:0]  m_motor_request,
    output logic        m_command_seen
);

    // Configuration registers
    logic [7:0] header_reg, trailer_reg, enable_reg, disable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg  <= mcfr_pkg::HEADER_RST;
            trailer_reg <= mcfr_pkg::TRAILER_RST;
            enable_reg  <= mcfr_pkg::ENABLE_RST;
            disable_reg <= mcfr_pkg::DISABLE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mcfr_pkg::CFG_HEADER:  header_reg  <= cfg_wr_data;
                mcfr_pkg::CFG_TRAILER: trailer_reg <= cfg_wr_data;
                mcfr_pkg::CFG_ENABLE:  enable_reg  <= cfg_wr_data;
                mcfr_pkg::CFG_DISABLE: disable_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Input register and handshake
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       in_last_reg, in_last_next;
    logic       out_free, proc_fire, res_load, s_fire;

    assign out_free  = !m_valid || m_ready;
    assign proc_fire = in_vld_reg && (!in_last_reg || out_free);
    assign res_load  = proc_fire && in_last_reg;
    assign s_ready   = !in_vld_reg || proc_fire;
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        in_vld_next  = s_fire || (in_vld_reg && !proc_fire);
        in_byte_next = s_fire ? s_rx_byte   : in_byte_reg;
        in_last_next = s_fire ? s_burst_end : in_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        in_last_reg <= in_last_next;
    end

    // Store, frame check and command decode
    logic [FRAME_BYTES-1:0][7:0] view;
    mcfr_pkg::store_ctrl_t       store_ctrl;
    mcfr_pkg::check_res_t        chk_res;
    mcfr_pkg::cmd_res_t          cmd_res;

    assign store_ctrl.write = proc_fire;
    assign store_ctrl.last  = in_last_reg;
    assign store_ctrl.clear = in_last_reg && chk_res.frame_valid;

    mcfr_frame_store #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (store_ctrl),
        .rx_byte (in_byte_reg),
        .view    (view)
    );

    mcfr_frame_check #(
        .FRAME_BYTES (FRAME_BYTES),
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_check (
        .view         (view),
        .header_byte  (header_reg),
        .trailer_byte (trailer_reg),
        .res          (chk_res)
    );

    mcfr_cmd_decode u_cmd (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .update       (res_load),
        .byte0        (view[0]),
        .byte1        (view[1]),
        .byte2        (view[2]),
        .enable_code  (enable_reg),
        .disable_code (disable_reg),
        .res          (cmd_res)
    );

    // Result register
    logic                 out_vld_reg, out_vld_next;
    mcfr_pkg::check_res_t out_chk_reg, out_chk_next;
    mcfr_pkg::cmd_res_t   out_cmd_reg, out_cmd_next;

    always_comb begin
        out_vld_next = res_load || (out_vld_reg && !m_ready);
        out_chk_next = res_load ? chk_res : out_chk_reg;
        out_cmd_next = res_load ? cmd_res : out_cmd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_chk_reg <= out_chk_next;
        out_cmd_reg <= out_cmd_next;
    end

    assign m_valid         = out_vld_reg;
    assign m_frame_valid   = out_chk_reg.frame_valid;
    assign m_preload_0     = out_chk_reg.preload[0];
    assign m_direction_0   = out_chk_reg.direction[0];
    assign m_preload_1     = out_chk_reg.preload[1];
    assign m_direction_1   = out_chk_reg.direction[1];
    assign m_preload_2     = out_chk_reg.preload[2];
    assign m_direction_2   = out_chk_reg.direction[2];
    assign m_preload_3     = out_chk_reg.preload[3];
    assign m_direction_3   = out_chk_reg.direction[3];
    assign m_report_enable = out_cmd_reg.report_enable;
    assign m_motor_request = out_cmd_reg.request;
    assign m_command_seen  = out_cmd_reg.command_seen;

    // Assertions
    `ASSERT_RST(a_req_needs_cmd, aclk, aresetn, (m_valid && m_motor_request != mcfr_pkg::REQ_NONE) |-> m_command_seen, "motor request without command burst")
    `ASSERT_RST(a_bad_frame_zero, aclk, aresetn, (m_valid && !m_frame_valid) |-> (m_preload_0 == 16'd0 && m_direction_0 == 16'd0 && m_preload_3 == 16'd0 && m_direction_3 == 16'd0), "motor fields set on failed frame")
    `ASSERT_RST(a_result_from_last, aclk, aresetn, $rose(m_valid) |-> $past(in_vld_reg && in_last_reg), "result word without burst end")
    `ASSERT_ALWAYS(a_ready_when_empty, aclk, (aresetn && !in_vld_reg) |-> s_ready, "input stage empty but not ready")

endmodule

// ===== rtl/mcfr_frame_store.sv =====
// Frame byte store with its write position.
// Presents the store as it looks once the current word is written.
// Depends on mcfr_pkg.
`timescale 1ns / 1ps

module mcfr_frame_store #(
    parameter int FRAME_BYTES = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mcfr_pkg::store_ctrl_t            ctrl,
    input  logic [7:0]                       rx_byte,
    output logic [FRAME_BYTES-1:0][7:0]      view
);

    localparam int WPOS_W = $clog2(FRAME_BYTES + 1);

    logic [FRAME_BYTES-1:0][7:0] store_reg, store_next;
    logic [WPOS_W-1:0]           wpos_reg, wpos_next;
    logic                        wpos_open;

    assign wpos_open = wpos_reg < WPOS_W'(FRAME_BYTES);

    // Current word overlays its slot; a full frame drops the word
    always_comb begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
            if (wpos_open && wpos_reg == WPOS_W'(i)) begin
                view[i] = rx_byte;
            end else begin
                view[i] = store_reg[i];
            end
        end
    end

    // Store and position update
    always_comb begin
        store_next = store_reg;
        wpos_next  = wpos_reg;
        if (ctrl.write) begin
            store_next = ctrl.clear ? '0 : view;
            if (ctrl.last) begin
                wpos_next = '0;
            end else if (wpos_open) begin
                wpos_next = wpos_reg + WPOS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_reg <= '0;
            wpos_reg  <= '0;
        end else begin
            store_reg <= store_next;
            wpos_reg  <= wpos_next;
        end
    end

endmodule

// ===== rtl/mcfr_frame_check.sv =====
// Frame check: header, trailer and XOR checksum, plus motor field extraction.
// Purely combinational; depends on mcfr_pkg.
`timescale 1ns / 1ps

module mcfr_frame_check #(
    parameter int FRAME_BYTES = 32,
    parameter int MOTOR_COUNT = 4
) (
    input  logic [FRAME_BYTES-1:0][7:0] view,
    input  logic [7:0]                  header_byte,
    input  logic [7:0]                  trailer_byte,
    output mcfr_pkg::check_res_t        res
);

    logic [7:0] chk;
    logic       valid;

    // XOR over every byte ahead of the checksum slot
    always_comb begin
        chk = '0;
        for (int i = 0; i < FRAME_BYTES - 2; i++) begin
            chk = chk ^ view[i];
        end
    end

    assign valid = (view[0] == header_byte)
                && (view[FRAME_BYTES-1] == trailer_byte)
                && (view[FRAME_BYTES-2] == chk);

    // Little-endian pairs, four bytes per motor from byte 2; zero when unused or on a failed check
    always_comb begin
        res.frame_valid = valid;
        for (int k = 0; k < mcfr_pkg::MAX_MOTORS; k++) begin
            if (valid && k < MOTOR_COUNT) begin
                res.preload[k]   = {view[4*k+3], view[4*k+2]};
                res.direction[k] = {view[4*k+5], view[4*k+4]};
            end else begin
                res.preload[k]   = '0;
                res.direction[k] = '0;
            end
        end
    end

endmodule

// ===== rtl/mcfr_cmd_decode.sv =====
// Command decode for bursts that open with 'A'; holds the report enable flag.
// Depends on mcfr_pkg.
`timescale 1ns / 1ps

module mcfr_cmd_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                update,
    input  logic [7:0]          byte0,
    input  logic [7:0]          byte1,
    input  logic [7:0]          byte2,
    input  logic [7:0]          enable_code,
    input  logic [7:0]          disable_code,
    output mcfr_pkg::cmd_res_t  res
);

    logic report_reg, report_next;
    logic cmd;

    assign cmd = (byte0 == mcfr_pkg::CMD_MARK);

    // Enable wins when both codes match; other codes change nothing
    always_comb begin
        report_next = report_reg;
        res.request = mcfr_pkg::REQ_NONE;
        if (cmd) begin
            priority if (byte1 == enable_code) begin
                report_next = 1'b1;
            end else if (byte1 == disable_code) begin
                report_next = 1'b0;
            end else begin
                report_next = report_reg;
            end
            priority if (byte2 == enable_code) begin
                res.request = mcfr_pkg::REQ_START;
            end else if (byte2 == disable_code) begin
                res.request = mcfr_pkg::REQ_STOP;
            end else begin
                res.request = mcfr_pkg::REQ_NONE;
            end
        end
        res.command_seen  = cmd;
        res.report_enable = report_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            report_reg <= 1'b0;
        end else if (update) begin
            report_reg <= report_next;
        end
    end

endmodule

// ===== tb/tb_motor_command_frame_receiver.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for motor_command_frame_receiver: a directed burst table,
// then randomized frames, commands and noise under several register settings.
// Depends on mcfr_pkg and the receiver RTL; needs no other files.

module tb_motor_command_frame_receiver;
    import mcfr_pkg::*;

    localparam int FRAME_LEN    = 32;
    localparam int MOTORS       = 4;
    localparam int DRAIN_CYCLES = 4;     // settling margin after the results drain
    localparam int IDLE_LIMIT   = 1000;  // cycles with no handshake or register write
    localparam int PHASE_WORDS  = 180;
    localparam int PHASES       = 5;

    // Register indexes past the last register; writes to them are dropped
    localparam logic [2:0] CFG_FIRST_SPARE = 3'd4;
    localparam logic [2:0] CFG_LAST_SPARE  = 3'd7;
    // A command byte that matches neither default code
    localparam logic [7:0] OTHER_CODE = 8'h7E;

    // Idle percentages per phase; the last phase runs without idling
    localparam int PHASE_GAP   [PHASES] = '{10, 30, 0, 25, 0};
    localparam int PHASE_STALL [PHASES] = '{10, 30, 20, 0, 0};

    typedef struct packed {
        logic                    frame_valid;
        logic [MOTORS-1:0][15:0] preload;
        logic [MOTORS-1:0][15:0] direction;
        logic                    report_enable;
        motor_req_t              request;
        logic                    command_seen;
    } frame_result_t;

    typedef enum logic [2:0] {
        B_RAW,        // bytes b0..b2, then fill
        B_FRAME,      // well-formed frame for the current registers
        B_BAD_SUM,    // frame with a broken checksum byte
        B_BAD_TRAIL,  // frame with a broken trailer
        B_BAD_HEAD    // frame with a broken header, checksum still over the good one
    } burst_kind_t;

    typedef struct packed {
        burst_kind_t kind;
        int          len;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        int          fill;      // fill byte, negative for random bytes
        logic        typed;     // expected result given below
        logic        ex_valid;
        logic [15:0] ex_word;   // every preload and direction
        logic        ex_report;
        motor_req_t  ex_req;
        logic        ex_cmd;
    } burst_row_t;

    // Directed bursts, starting from reset values of every register
    localparam burst_row_t DIRECTED [18] = '{
        // lone zero byte on a clear store: nothing matches
        '{B_RAW, 1, 8'h00, 8'h00, 8'h00, 0, 1'b1, 1'b0, 16'h0000, 1'b0, REQ_NONE, 1'b0},
        '{B_RAW, 3, CMD_MARK, ENABLE_RST, ENABLE_RST, 0,
          1'b1, 1'b0, 16'h0000, 1'b1, REQ_START, 1'b1},
        '{B_RAW, 3, CMD_MARK, DISABLE_RST, DISABLE_RST, 0,
          1'b1, 1'b0, 16'h0000, 1'b0, REQ_STOP, 1'b1},
        // command bytes matching neither code leave flag or request alone
        '{B_RAW, 3, CMD_MARK, ENABLE_RST, OTHER_CODE, 0,
          1'b1, 1'b0, 16'h0000, 1'b1, REQ_NONE, 1'b1},
        '{B_RAW, 3, CMD_MARK, OTHER_CODE, DISABLE_RST, 0,
          1'b1, 1'b0, 16'h0000, 1'b1, REQ_STOP, 1'b1},
        // short command: bytes 1 and 2 come from the store
        '{B_RAW, 1, CMD_MARK, 8'h00, 8'h00, 0, 1'b0, 1'b0, 16'h0000, 1'b0, REQ_NONE, 1'b0},
        '{B_FRAME, 32, 8'h00, 8'h00, 8'h00, 8'h00,
          1'b1, 1'b1, 16'h0000, 1'b1, REQ_NONE, 1'b0},
        '{B_FRAME, 32, 8'h00, 8'h00, 8'h00, 8'hFF,
          1'b1, 1'b1, 16'hFFFF, 1'b1, REQ_NONE, 1'b0},
        '{B_FRAME, 32, 8'h00, 8'h00, 8'h00, -1, 1'b0, 1'b0, 16'h0000, 1'b0, REQ_NONE, 1'b0},
        '{B_BAD_SUM, 32, 8'h00, 8'h00, 8'h00, -1,
          1'b1, 1'b0, 16'h0000, 1'b1, REQ_NONE, 1'b0},
        '{B_BAD_HEAD, 32, 8'h00, 8'h00, 8'h00, -1,
          1'b1, 1'b0, 16'h0000, 1'b1, REQ_NONE, 1'b0},
        // one-byte burst fixes the header of the stale frame
        '{B_RAW, 1, HEADER_RST, 8'h00, 8'h00, 0, 1'b0, 1'b0, 16'h0000, 1'b0, REQ_NONE, 1'b0},
        '{B_BAD_TRAIL, 32, 8'h00, 8'h00, 8'h00, -1,
          1'b1, 1'b0, 16'h0000, 1'b1, REQ_NONE, 1'b0},
        // overlong, partial, noise, and far past the end of the store
        '{B_FRAME, 40, 8'h00, 8'h00, 8'h00, -1, 1'b0, 1'b0, 16'h0000, 1'b0, REQ_NONE, 1'b0},
        '{B_FRAME, 16, 8'h00, 8'h00, 8'h00, -1, 1'b0, 1'b0, 16'h0000, 1'b0, REQ_NONE, 1'b0},
        '{B_RAW, 20, 8'h00, 8'hFF, 8'h80, -1, 1'b0, 1'b0, 16'h0000, 1'b0, REQ_NONE, 1'b0},
        '{B_FRAME, 64, 8'h00, 8'h00, 8'h00, 8'hA5, 1'b0, 1'b0, 16'h0000, 1'b0, REQ_NONE, 1'b0},
        '{B_RAW, 3, CMD_MARK, DISABLE_RST, ENABLE_RST, 0,
          1'b1, 1'b0, 16'h0000, 1'b0, REQ_START, 1'b1}
    };

    // DUT connections
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [2:0]  cfg_index   = CFG_HEADER;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte   = 8'h00;
    logic        s_burst_end = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic        m_frame_valid;
    logic [15:0] m_preload_0, m_direction_0, m_preload_1, m_direction_1;
    logic [15:0] m_preload_2, m_direction_2, m_preload_3, m_direction_3;
    logic        m_report_enable;
    logic [1:0]  m_motor_request;
    logic        m_command_seen;

    // Mirror of the receiver state and registers
    logic [7:0] mirror_store [FRAME_LEN] = '{default: 8'h00};
    int         mirror_wpos   = 0;
    logic       mirror_report = 1'b0;
    logic [7:0] hdr_code = HEADER_RST;
    logic [7:0] trl_code = TRAILER_RST;
    logic [7:0] en_code  = ENABLE_RST;
    logic [7:0] dis_code = DISABLE_RST;

    frame_result_t pending_frames [$];
    logic [7:0]    burst_q [$];
    logic [7:0]    frame_img [FRAME_LEN];
    int            mismatches  = 0;
    int            gap_pct     = 0;
    int            stall_pct   = 0;
    int            stall_left  = 0;
    int            idle_cycles = 0;

    motor_command_frame_receiver dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_burst_end     (s_burst_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_valid   (m_frame_valid),
        .m_preload_0     (m_preload_0),
        .m_direction_0   (m_direction_0),
        .m_preload_1     (m_preload_1),
        .m_direction_1   (m_direction_1),
        .m_preload_2     (m_preload_2),
        .m_direction_2   (m_direction_2),
        .m_preload_3     (m_preload_3),
        .m_direction_3   (m_direction_3),
        .m_report_enable (m_report_enable),
        .m_motor_request (m_motor_request),
        .m_command_seen  (m_command_seen)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Advance the mirror by one accepted word; a burst end yields a result
    function automatic void mirror_rx_byte(input logic [7:0] b, input logic last,
                                           output bit has, output frame_result_t r);
        logic [7:0] sum;
        logic       ok;
        r   = '0;
        has = last;
        if (mirror_wpos < FRAME_LEN) begin
            mirror_store[mirror_wpos] = b;
            mirror_wpos++;
        end
        if (last) begin
            mirror_wpos    = 0;
            r.request      = REQ_NONE;
            r.command_seen = (mirror_store[0] == CMD_MARK);
            // command decode sees the store before any clear
            if (r.command_seen) begin
                if (mirror_store[1] == en_code)
                    mirror_report = 1'b1;
                else if (mirror_store[1] == dis_code)
                    mirror_report = 1'b0;
                if (mirror_store[2] == en_code)
                    r.request = REQ_START;
                else if (mirror_store[2] == dis_code)
                    r.request = REQ_STOP;
            end
            sum = 8'h00;
            for (int i = 0; i < FRAME_LEN - 2; i++)
                sum ^= mirror_store[i];
            ok = (mirror_store[0] == hdr_code) && (mirror_store[FRAME_LEN-1] == trl_code)
                 && (mirror_store[FRAME_LEN-2] == sum);
            if (ok) begin
                for (int k = 0; k < MOTORS; k++) begin
                    r.preload[k]   = {mirror_store[4*k+3], mirror_store[4*k+2]};
                    r.direction[k] = {mirror_store[4*k+5], mirror_store[4*k+4]};
                end
                foreach (mirror_store[i])
                    mirror_store[i] = 8'h00;
            end
            r.frame_valid   = ok;
            r.report_enable = mirror_report;
        end
    endfunction

    function automatic logic [7:0] fill_byte(input int fill);
        return (fill < 0) ? 8'($urandom) : 8'(fill);
    endfunction

    // Command byte that hits the enable code, the disable code or anything
    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 2))
            0:       return en_code;
            1:       return dis_code;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] one_bit();
        return 8'(1 << $urandom_range(0, 7));
    endfunction

    // Fill burst_q with the bytes of one burst
    task automatic build_burst(input burst_kind_t kind, input int len, input logic [7:0] b0,
                               input logic [7:0] b1, input logic [7:0] b2, input int fill);
        logic [7:0] sum;
        burst_q.delete();
        if (kind == B_RAW) begin
            for (int i = 0; i < len; i++)
                burst_q.push_back(i == 0 ? b0 : i == 1 ? b1 : i == 2 ? b2 : fill_byte(fill));
        end else begin
            frame_img[0] = hdr_code;
            for (int i = 1; i < FRAME_LEN - 2; i++)
                frame_img[i] = fill_byte(fill);
            if (fill < 0) begin
                frame_img[1] = pick_code();
                frame_img[2] = pick_code();
            end
            sum = 8'h00;
            for (int i = 0; i < FRAME_LEN - 2; i++)
                sum ^= frame_img[i];
            frame_img[FRAME_LEN-2] = sum;
            frame_img[FRAME_LEN-1] = trl_code;
            case (kind)
                B_BAD_SUM:   frame_img[FRAME_LEN-2] ^= one_bit();
                B_BAD_TRAIL: frame_img[FRAME_LEN-1] ^= one_bit();
                B_BAD_HEAD:  frame_img[0] ^= one_bit();
                default: ;
            endcase
            for (int i = 0; i < len; i++)
                burst_q.push_back(i < FRAME_LEN ? frame_img[i] : fill_byte(fill));
        end
    endtask

    // Offer one word, with an optional gap first, and mirror it on acceptance
    task automatic put_word(input logic [7:0] b, input logic last,
                            output bit has, output frame_result_t r);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_rx_byte   <= b;
        s_burst_end <= last;
        do @(posedge aclk); while (!s_ready);
        mirror_rx_byte(b, last, has, r);
    endtask

    task automatic send_burst(input bit typed, input frame_result_t typed_res);
        bit            has;
        frame_result_t r;
        foreach (burst_q[i]) begin
            put_word(burst_q[i], i == burst_q.size() - 1, has, r);
            if (has)
                pending_frames.push_back(typed ? typed_res : r);
        end
    endtask

    // Hold off the sender until every result is back
    task automatic wait_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_frames.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        case (idx)
            CFG_HEADER:  hdr_code = val;
            CFG_TRAILER: trl_code = val;
            CFG_ENABLE:  en_code  = val;
            CFG_DISABLE: dis_code = val;
            default: ;
        endcase
    endtask

    // One stretch of random bursts, well-formed frames the most common kind
    task automatic run_phase(input int target);
        int          sent;
        int          pick;
        bit          paused;
        burst_kind_t bad;
        sent   = 0;
        paused = 1'b0;
        while (sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                build_burst(B_FRAME, ($urandom_range(0, 5) == 0) ? $urandom_range(33, 48)
                            : FRAME_LEN, 8'h00, 8'h00, 8'h00, -1);
            end else if (pick < 60) begin
                case ($urandom_range(0, 2))
                    0:       bad = B_BAD_SUM;
                    1:       bad = B_BAD_TRAIL;
                    default: bad = B_BAD_HEAD;
                endcase
                build_burst(bad, FRAME_LEN, 8'h00, 8'h00, 8'h00, -1);
            end else if (pick < 75) begin
                build_burst(B_RAW, $urandom_range(1, 8), CMD_MARK, pick_code(), pick_code(), -1);
            end else if (pick < 85) begin
                // cut-off frame, leaves its bytes in the store
                build_burst(B_FRAME, $urandom_range(1, 31), 8'h00, 8'h00, 8'h00, -1);
            end else begin
                build_burst(B_RAW, $urandom_range(1, 40),
                            $urandom_range(0, 1) ? hdr_code : 8'($urandom),
                            8'($urandom), 8'($urandom), -1);
            end
            send_burst(1'b0, '0);
            sent += burst_q.size();
            if (!paused && sent >= target / 2) begin
                paused = 1'b1;
                wait_results();
            end
        end
    endtask

    // Main sequence
    initial begin : stimulus
        frame_result_t typed_res;
        burst_row_t    row;
        logic [7:0]    regs [4];
        repeat (10) @(posedge aclk);
        aresetn   <= 1'b1;
        gap_pct   = 10;
        stall_pct = 10;

        foreach (DIRECTED[i]) begin
            row = DIRECTED[i];
            build_burst(row.kind, row.len, row.b0, row.b1, row.b2, row.fill);
            typed_res.frame_valid = row.ex_valid;
            for (int k = 0; k < MOTORS; k++) begin
                typed_res.preload[k]   = row.ex_word;
                typed_res.direction[k] = row.ex_word;
            end
            typed_res.report_enable = row.ex_report;
            typed_res.request       = row.ex_req;
            typed_res.command_seen  = row.ex_cmd;
            send_burst(row.typed, typed_res);
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_results();
            repeat (DRAIN_CYCLES) @(posedge aclk);
            case (p)
                // extremes, equal codes so enable must win
                0: regs = '{8'hFF, 8'h00, 8'hFF, 8'hFF};
                1: regs = '{8'h00, 8'hFF, 8'h00, 8'h01};
                // header doubles as the command mark
                2: regs = '{CMD_MARK, 8'($urandom), 8'($urandom), 8'($urandom)};
                3: regs = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
                default: regs = '{HEADER_RST, TRAILER_RST, ENABLE_RST, DISABLE_RST};
            endcase
            cfg_write(3'($urandom_range(CFG_FIRST_SPARE, CFG_LAST_SPARE)), 8'($urandom));
            cfg_write(CFG_HEADER,  regs[0]);
            cfg_write(CFG_TRAILER, regs[1]);
            cfg_write(CFG_ENABLE,  regs[2]);
            cfg_write(CFG_DISABLE, regs[3]);
            cfg_wr_en <= 1'b0;
            gap_pct   = PHASE_GAP[p];
            stall_pct = PHASE_STALL[p];
            run_phase(PHASE_WORDS);
        end

        wait_results();
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("motor_command_frame_receiver regression: pass");
        else
            $display("motor_command_frame_receiver regression: fail");
        $finish;
    end

    // Result side: ready drops in random bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_pct != 0 && $urandom_range(0, 399) < stall_pct) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 18);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare each result word with the oldest expectation
    always @(posedge aclk) begin
        frame_result_t got;
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.frame_valid   = m_frame_valid;
            got.preload       = {m_preload_3, m_preload_2, m_preload_1, m_preload_0};
            got.direction     = {m_direction_3, m_direction_2, m_direction_1, m_direction_0};
            got.report_enable = m_report_enable;
            got.request       = motor_req_t'(m_motor_request);
            got.command_seen  = m_command_seen;
            if (pending_frames.size() == 0) begin
                $error("result word with no burst end waiting for it");
                mismatches++;
            end else begin
                want = pending_frames.pop_front();
                check_field("frame_valid", 16'(want.frame_valid), 16'(got.frame_valid));
                for (int k = 0; k < MOTORS; k++) begin
                    check_field($sformatf("preload_%0d", k), want.preload[k], got.preload[k]);
                    check_field($sformatf("direction_%0d", k), want.direction[k],
                                got.direction[k]);
                end
                check_field("report_enable", 16'(want.report_enable), 16'(got.report_enable));
                check_field("motor_request", 16'(want.request), 16'(got.request));
                check_field("command_seen", 16'(want.command_seen), 16'(got.command_seen));
            end
        end
    end

    // Watchdog on cycles without any handshake or register write
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("motor_command_frame_receiver regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mcfr_pkg.sv
rtl/mcfr_frame_store.sv
rtl/mcfr_frame_check.sv
rtl/mcfr_cmd_decode.sv
rtl/motor_command_frame_receiver.sv
tb/tb_motor_command_frame_receiver.sv
